/* rtl/rre_pkg.sv */
// shared types and constants for the ray rectangle exit point unit
`timescale 1ns / 1ps
`default_nettype none

package rre_pkg;

    // coordinate and register widths
    localparam int COORD_W    = 32;
    localparam int EPS_W      = 16;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // register map, index is paddr[4:2]
    typedef enum logic [2:0] {
        CFG_MIN_X = 3'd0,
        CFG_MAX_X = 3'd1,
        CFG_MIN_Z = 3'd2,
        CFG_MAX_Z = 3'd3,
        CFG_EPS   = 3'd4
    } t_cfg_idx;

    // reset values of the bounds and threshold
    localparam logic signed [COORD_W-1:0] RST_MIN_X = -32'sd3932160;
    localparam logic signed [COORD_W-1:0] RST_MAX_X = 32'sd3932160;
    localparam logic signed [COORD_W-1:0] RST_MIN_Z = -32'sd6553600;
    localparam logic signed [COORD_W-1:0] RST_MAX_Z = 32'sd1310720;
    localparam logic [EPS_W-1:0]          RST_EPS   = 16'd7;

    // saturation limits of the coordinate format
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    // a point carried along the pipe
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_xyz;

endpackage

`default_nettype wire

/* rtl/rre_if.sv */
// stream interfaces for query words and result words
`timescale 1ns / 1ps
`default_nettype none

interface rre_in_if;
    import rre_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] heading_x;
    logic signed [COORD_W-1:0] heading_z;

    modport source (output valid, start_x, start_y, start_z, heading_x, heading_z,
                    input ready);
    modport sink (input valid, start_x, start_y, start_z, heading_x, heading_z,
                  output ready);
endinterface

interface rre_out_if;
    import rre_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;

    modport source (output valid, end_x, end_y, end_z, input ready);
    modport sink (input valid, end_x, end_y, end_z, output ready);
endinterface

`default_nettype wire

/* rtl/ray_rectangle_exit_point_unit.sv */
// top level: ray to rectangle exit point pipeline with register port
//
// Query words arrive on i_in (start point and x/z heading, signed fixed point
// with COORD_FRAC_BITS fraction bits); result words leave on o_out (exit point
// on the rectangle, y copied). One result word per query word, in order.
// Bounds and threshold are to be written on the register port only while no
// query is in flight, not enforced by the block; writes apply to the next query.
// Throughput: one word per cycle while the output does not stall. The pipe is
// the 32 stage square root and the two divider pipes of 32 + COORD_FRAC_BITS
// stages each (unit heading, then wall distance), plus six arithmetic and
// output stages.
// The whole pipe advances together: when the receiver stalls a valid result,
// every stage holds and i_in.ready drops in the same cycle; nothing is lost
// or repeated. A valid result is shown until it is taken.
// Reset clears all valid bits and loads the default bounds and threshold.
`timescale 1ns / 1ps
`default_nettype none

module ray_rectangle_exit_point_unit #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    rre_in_if.sink                                i_in,
    rre_out_if.source                             o_out,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [rre_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [rre_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [rre_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                  pready
);
    import rre_pkg::*;

    localparam int F      = COORD_FRAC_BITS;
    localparam int UW     = F + 2;            // signed unit component
    localparam int QW     = F + 1;            // unit magnitude
    localparam int DIV_NW = COORD_W + F;      // dividend width of every divider
    localparam int TW     = COORD_W + 2;      // signed distance t
    localparam int CW     = TW + F;           // signed wall candidate
    localparam int PW     = UW + TW;          // offset product
    localparam int SQ_SW  = 3 * COORD_W + 2 * COORD_W;
    localparam int UX_SW  = 3 * COORD_W + 2;
    localparam int WX_SW  = 3 * COORD_W + 1 + 2 * UW + 2;

    // ---------------- register port ----------------
    logic signed [COORD_W-1:0] r_min_x, r_max_x, r_min_z, r_max_z;
    logic [EPS_W-1:0]          r_eps;
    logic [2:0]                cfg_idx;
    logic                      cfg_wr;

    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= RST_MIN_X;
            r_max_x <= RST_MAX_X;
            r_min_z <= RST_MIN_Z;
            r_max_z <= RST_MAX_Z;
            r_eps   <= RST_EPS;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                CFG_MIN_X: r_min_x <= $signed(pwdata);
                CFG_MAX_X: r_max_x <= $signed(pwdata);
                CFG_MIN_Z: r_min_z <= $signed(pwdata);
                CFG_MAX_Z: r_max_z <= $signed(pwdata);
                CFG_EPS:   r_eps   <= pwdata[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (cfg_idx)
            CFG_MIN_X: prdata = r_min_x;
            CFG_MAX_X: prdata = r_max_x;
            CFG_MIN_Z: prdata = r_min_z;
            CFG_MAX_Z: prdata = r_max_z;
            CFG_EPS:   prdata = CFG_DATA_W'(r_eps);
            default:   prdata = '0;
        endcase
    end

    // ---------------- pipe advance ----------------
    logic en;
    logic r_o_v;

    assign en         = !r_o_v || o_out.ready;
    assign i_in.ready = en;

    // ---------------- stage a: heading squares ----------------
    logic [COORD_W-1:0]        in_ax, in_az;
    logic                      r_a_v;
    t_xyz                      r_a_pt;
    logic signed [COORD_W-1:0] r_a_hx, r_a_hz;
    logic [2*COORD_W-1:0]      r_a_sqx, r_a_sqz;

    assign in_ax = i_in.heading_x[COORD_W-1] ? COORD_W'(-i_in.heading_x) : i_in.heading_x;
    assign in_az = i_in.heading_z[COORD_W-1] ? COORD_W'(-i_in.heading_z) : i_in.heading_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_pt  <= '{x: i_in.start_x, y: i_in.start_y, z: i_in.start_z};
            r_a_hx  <= i_in.heading_x;
            r_a_hz  <= i_in.heading_z;
            r_a_sqx <= (2*COORD_W)'(in_ax) * (2*COORD_W)'(in_ax);
            r_a_sqz <= (2*COORD_W)'(in_az) * (2*COORD_W)'(in_az);
        end
    end

    // ---------------- stage b: squared length ----------------
    logic                      r_b_v;
    t_xyz                      r_b_pt;
    logic signed [COORD_W-1:0] r_b_hx, r_b_hz;
    logic [2*COORD_W-1:0]      r_b_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_pt  <= r_a_pt;
            r_b_hx  <= r_a_hx;
            r_b_hz  <= r_a_hz;
            r_b_rad <= r_a_sqx + r_a_sqz;
        end
    end

    // ---------------- heading length ----------------
    logic                      sq_v;
    logic [COORD_W-1:0]        sq_len;
    logic [SQ_SW-1:0]          sq_side;
    t_xyz                      sq_pt;
    logic signed [COORD_W-1:0] sq_hx, sq_hz;

    rre_isqrt #(.SIDE_W(SQ_SW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_v),
        .i_rad   (r_b_rad),
        .i_side  ({r_b_pt, r_b_hx, r_b_hz}),
        .o_valid (sq_v),
        .o_root  (sq_len),
        .o_side  (sq_side)
    );

    assign {sq_pt, sq_hx, sq_hz} = sq_side;

    // ---------------- unit heading dividers ----------------
    logic [COORD_W-1:0] sq_ax, sq_az;
    logic               sq_use;
    logic               udx_v, udz_v;
    logic [DIV_NW-1:0]  udx_q, udz_q;
    logic [UX_SW-1:0]   udx_side;
    logic               udz_side;
    t_xyz               ud_pt;
    logic               ud_sgnx, ud_use;

    assign sq_ax  = sq_hx[COORD_W-1] ? COORD_W'(-sq_hx) : sq_hx;
    assign sq_az  = sq_hz[COORD_W-1] ? COORD_W'(-sq_hz) : sq_hz;
    assign sq_use = (sq_len >= COORD_W'(r_eps)) && (sq_len != '0);

    rre_udiv #(.NUM_W(DIV_NW), .DEN_W(COORD_W), .SIDE_W(UX_SW)) u_udiv_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_num   ({sq_ax, {F{1'b0}}}),
        .i_den   (sq_len),
        .i_side  ({sq_pt, sq_hx[COORD_W-1], sq_use}),
        .o_valid (udx_v),
        .o_quo   (udx_q),
        .o_side  (udx_side)
    );

    rre_udiv #(.NUM_W(DIV_NW), .DEN_W(COORD_W), .SIDE_W(1)) u_udiv_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_num   ({sq_az, {F{1'b0}}}),
        .i_den   (sq_len),
        .i_side  (sq_hz[COORD_W-1]),
        .o_valid (udz_v),
        .o_quo   (udz_q),
        .o_side  (udz_side)
    );

    assign {ud_pt, ud_sgnx, ud_use} = udx_side;

    // ---------------- stage u: signed unit and wall selection ----------------
    logic signed [UW-1:0] ux_c, uz_c;
    logic signed [CW-1:0] eps_w;
    logic                 r_u_v, r_u_use;
    t_xyz                 r_u_pt;
    logic signed [UW-1:0] r_u_ux, r_u_uz;
    logic                 r_u_px, r_u_nx, r_u_pz, r_u_nz;

    assign ux_c  = ud_sgnx ? -$signed({1'b0, udx_q[QW-1:0]}) : $signed({1'b0, udx_q[QW-1:0]});
    assign uz_c  = udz_side ? -$signed({1'b0, udz_q[QW-1:0]}) : $signed({1'b0, udz_q[QW-1:0]});
    assign eps_w = $signed(CW'(r_eps));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_v <= 1'b0;
        end else if (en) begin
            r_u_v <= udx_v && udz_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u_pt  <= ud_pt;
            r_u_use <= ud_use;
            r_u_ux  <= ux_c;
            r_u_uz  <= uz_c;
            r_u_px  <= CW'(ux_c) > eps_w;
            r_u_nx  <= CW'(ux_c) < -eps_w;
            r_u_pz  <= CW'(uz_c) > eps_w;
            r_u_nz  <= CW'(uz_c) < -eps_w;
        end
    end

    // ---------------- wall distance dividers ----------------
    logic signed [COORD_W-1:0] wall_x, wall_z;
    logic signed [COORD_W:0]   dx, dz;
    logic [COORD_W:0]          mx, mz;
    logic [UW-1:0]             den_x, den_z;
    logic                      wdx_v, wdz_v;
    logic [DIV_NW-1:0]         wdx_q, wdz_q;
    logic [WX_SW-1:0]          wdx_side;
    logic [1:0]                wdz_side;
    t_xyz                      wd_pt;
    logic                      wd_use, wd_hitx, wd_sgnx;
    logic signed [UW-1:0]      wd_ux, wd_uz;

    assign wall_x = r_u_px ? r_max_x : r_min_x;
    assign wall_z = r_u_pz ? r_max_z : r_min_z;
    assign dx     = (COORD_W+1)'(wall_x) - (COORD_W+1)'(r_u_pt.x);
    assign dz     = (COORD_W+1)'(wall_z) - (COORD_W+1)'(r_u_pt.z);
    assign mx     = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
    assign mz     = dz[COORD_W] ? (COORD_W+1)'(-dz) : dz;
    assign den_x  = r_u_ux[UW-1] ? UW'(-r_u_ux) : r_u_ux;
    assign den_z  = r_u_uz[UW-1] ? UW'(-r_u_uz) : r_u_uz;

    rre_udiv #(.NUM_W(DIV_NW), .DEN_W(QW), .SIDE_W(WX_SW)) u_wdiv_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_u_v),
        .i_num   ({mx[COORD_W-1:0], {F{1'b0}}}),
        .i_den   (den_x[QW-1:0]),
        .i_side  ({r_u_pt, r_u_use, r_u_ux, r_u_uz, r_u_px || r_u_nx, dx[COORD_W] ^ r_u_nx}),
        .o_valid (wdx_v),
        .o_quo   (wdx_q),
        .o_side  (wdx_side)
    );

    rre_udiv #(.NUM_W(DIV_NW), .DEN_W(QW), .SIDE_W(2)) u_wdiv_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_u_v),
        .i_num   ({mz[COORD_W-1:0], {F{1'b0}}}),
        .i_den   (den_z[QW-1:0]),
        .i_side  ({r_u_pz || r_u_nz, dz[COORD_W] ^ r_u_nz}),
        .o_valid (wdz_v),
        .o_quo   (wdz_q),
        .o_side  (wdz_side)
    );

    assign {wd_pt, wd_use, wd_ux, wd_uz, wd_hitx, wd_sgnx} = wdx_side;

    // ---------------- stage t: nearest wall, clamp ----------------
    logic signed [CW-1:0] cand_x, cand_z, span, t_1, t_2;
    logic                 r_t_v, r_t_use;
    t_xyz                 r_t_pt;
    logic signed [UW-1:0] r_t_ux, r_t_uz;
    logic signed [TW-1:0] r_t_t;

    assign cand_x = wd_sgnx ? -$signed(CW'(wdx_q)) : $signed(CW'(wdx_q));
    assign cand_z = wdz_side[0] ? -$signed(CW'(wdz_q)) : $signed(CW'(wdz_q));
    assign span   = CW'(r_max_x) - CW'(r_min_x) + CW'(r_max_z) - CW'(r_min_z);
    assign t_1    = (wd_hitx && (cand_x < span)) ? cand_x : span;
    assign t_2    = (wdz_side[1] && (cand_z < t_1)) ? cand_z : t_1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_v <= 1'b0;
        end else if (en) begin
            r_t_v <= wdx_v && wdz_v;
        end
    end

    // a short heading gets t of zero, so the end point is the start point
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t_pt  <= wd_pt;
            r_t_use <= wd_use;
            r_t_ux  <= wd_ux;
            r_t_uz  <= wd_uz;
            r_t_t   <= (!wd_use || t_2[CW-1]) ? '0 : t_2[TW-1:0];
        end
    end

    // ---------------- stage m: offset products ----------------
    logic                 r_m_v;
    t_xyz                 r_m_pt;
    logic signed [PW-1:0] r_m_px, r_m_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (en) begin
            r_m_v <= r_t_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_pt <= r_t_pt;
            r_m_px <= PW'(r_t_ux) * PW'(r_t_t);
            r_m_pz <= PW'(r_t_uz) * PW'(r_t_t);
        end
    end

    // ---------------- stage o: add, saturate, output register ----------------
    localparam logic signed [PW:0] SAT_HI = (PW+1)'(COORD_MAX);
    localparam logic signed [PW:0] SAT_LO = (PW+1)'(COORD_MIN);

    logic signed [PW-1:0]      off_x, off_z;
    logic signed [PW:0]        sum_x, sum_z;
    logic signed [COORD_W-1:0] end_x_c, end_z_c;
    t_xyz                      r_o_pt;

    assign off_x = r_m_px >>> F;
    assign off_z = r_m_pz >>> F;
    assign sum_x = (PW+1)'(r_m_pt.x) + (PW+1)'(off_x);
    assign sum_z = (PW+1)'(r_m_pt.z) + (PW+1)'(off_z);

    always_comb begin
        if (sum_x > SAT_HI) begin
            end_x_c = COORD_MAX;
        end else if (sum_x < SAT_LO) begin
            end_x_c = COORD_MIN;
        end else begin
            end_x_c = sum_x[COORD_W-1:0];
        end
        if (sum_z > SAT_HI) begin
            end_z_c = COORD_MAX;
        end else if (sum_z < SAT_LO) begin
            end_z_c = COORD_MIN;
        end else begin
            end_z_c = sum_z[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en) begin
            r_o_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_pt <= '{x: end_x_c, y: r_m_pt.y, z: end_z_c};
        end
    end

    assign o_out.valid = r_o_v;
    assign o_out.end_x = r_o_pt.x;
    assign o_out.end_y = r_o_pt.y;
    assign o_out.end_z = r_o_pt.z;

    // ---------------- assertions ----------------
    a_rst_no_word: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result word valid right after reset");

    a_t_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t_v |-> !r_t_t[TW-1])
        else $error("clamped distance is negative");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_t_v && !r_t_use) |-> (r_t_t == '0))
        else $error("short heading did not force zero distance");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |=> ($stable(r_t_t) && $stable(r_m_px)))
        else $error("pipe moved while the output was stalled");

endmodule

`default_nettype wire

/* rtl/rre_isqrt.sv */
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none

module rre_isqrt #(
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [63:0]       i_rad,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [31:0]            o_root,
    output logic [SIDE_W-1:0]      o_side
);
    localparam int RAD_W  = 64;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic              r_v    [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_st
        logic              src_v;
        logic [RAD_W-1:0]  src_rad;
        logic [REM_W-1:0]  src_rem;
        logic [ROOT_W-1:0] src_root;
        logic [SIDE_W-1:0] src_side;
        logic [REM_W+1:0]  cat;
        logic [REM_W+1:0]  trial;
        logic              fits;

        // stage source: ports for the first stage, previous stage otherwise
        if (s == 0) begin : g_head
            assign src_v    = i_valid;
            assign src_rad  = i_rad;
            assign src_rem  = '0;
            assign src_root = '0;
            assign src_side = i_side;
        end else begin : g_body
            assign src_v    = r_v[s-1];
            assign src_rad  = r_rad[s-1];
            assign src_rem  = r_rem[s-1];
            assign src_root = r_root[s-1];
            assign src_side = r_side[s-1];
        end

        // bring down two radicand bits and try the next root bit
        assign cat   = {src_rem, src_rad[RAD_W-1 -: 2]};
        assign trial = {2'b00, src_root, 2'b01};
        assign fits  = (cat >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= fits ? REM_W'(cat - trial) : REM_W'(cat);
                r_root[s] <= {src_root[ROOT_W-2:0], fits};
                r_rad[s]  <= {src_rad[RAD_W-3:0], 2'b00};
                r_side[s] <= src_side;
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

`default_nettype wire

/* rtl/rre_udiv.sv */
// pipelined restoring unsigned divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module rre_udiv #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 32,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [NUM_W-1:0]       o_quo,
    output logic [SIDE_W-1:0]      o_side
);
    logic              r_v    [NUM_W];
    logic [NUM_W-1:0]  r_nq   [NUM_W];
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_st
        logic              src_v;
        logic [NUM_W-1:0]  src_nq;
        logic [DEN_W-1:0]  src_rem;
        logic [DEN_W-1:0]  src_den;
        logic [SIDE_W-1:0] src_side;
        logic [DEN_W:0]    cat;
        logic              fits;

        // stage source
        if (s == 0) begin : g_head
            assign src_v    = i_valid;
            assign src_nq   = i_num;
            assign src_rem  = '0;
            assign src_den  = i_den;
            assign src_side = i_side;
        end else begin : g_body
            assign src_v    = r_v[s-1];
            assign src_nq   = r_nq[s-1];
            assign src_rem  = r_rem[s-1];
            assign src_den  = r_den[s-1];
            assign src_side = r_side[s-1];
        end

        // shift in the next dividend bit, subtract when it fits
        assign cat  = {src_rem, src_nq[NUM_W-1]};
        assign fits = (cat >= {1'b0, src_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= fits ? DEN_W'(cat - {1'b0, src_den}) : DEN_W'(cat);
                r_nq[s]   <= {src_nq[NUM_W-2:0], fits};
                r_den[s]  <= src_den;
                r_side[s] <= src_side;
            end
        end
    end

    assign o_valid = r_v[NUM_W-1];
    assign o_quo   = r_nq[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench for the ray rectangle exit point unit with a self-checking scoreboard
`timescale 1ns / 1ps

module testbench;
    import rre_pkg::*;

    localparam int FRAC       = 16;
    localparam int DRAIN_WAIT = 200;
    localparam int CYCLE_CAP  = 400000;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    rre_in_if  query_if ();
    rre_out_if point_if ();

    ray_rectangle_exit_point_unit #(.COORD_FRAC_BITS(FRAC)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (query_if.sink),
        .o_out   (point_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // exit point predictor and expected point store
    class exit_point_board;
        longint lo_x, hi_x, lo_z, hi_z, eps;
        t_xyz   pending_points[$];
        int     errors;

        function new();
            lo_x = RST_MIN_X; hi_x = RST_MAX_X;
            lo_z = RST_MIN_Z; hi_z = RST_MAX_Z;
            eps = RST_EPS;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (t_cfg_idx'(idx))
                CFG_MIN_X: lo_x = longint'($signed(val));
                CFG_MAX_X: hi_x = longint'($signed(val));
                CFG_MIN_Z: lo_z = longint'($signed(val));
                CFG_MAX_Z: hi_z = longint'($signed(val));
                CFG_EPS:   eps = longint'(val[EPS_W-1:0]);
                default: ;
            endcase
        endfunction

        function longint unsigned root64(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint clamp32(longint v);
            if (v > longint'(COORD_MAX)) return COORD_MAX;
            if (v < longint'(COORD_MIN)) return COORD_MIN;
            return v;
        endfunction

        // wall distance along one unit component, keep the nearest
        function longint nearer(longint t, longint wall, longint st, longint u);
            longint cand;
            cand = ((wall - st) * (64'sd1 <<< FRAC)) / u;
            return (cand < t) ? cand : t;
        endfunction

        function void note_query(logic signed [31:0] sx, sy, sz, hx, hz);
            longint x, z, ax, az, len, ux, uz, t;
            t_xyz p;
            x = sx; z = sz;
            ax = (hx < 0) ? -longint'(hx) : longint'(hx);
            az = (hz < 0) ? -longint'(hz) : longint'(hz);
            len = longint'(root64(longint'(ax * ax) + longint'(az * az)));
            p.x = sx; p.y = sy; p.z = sz;
            if (len >= eps && len > 0) begin
                ux = (longint'(hx) * (64'sd1 <<< FRAC)) / len;
                uz = (longint'(hz) * (64'sd1 <<< FRAC)) / len;
                t = (hi_x - lo_x) + (hi_z - lo_z);
                if (ux > eps)  t = nearer(t, hi_x, x, ux);
                if (ux < -eps) t = nearer(t, lo_x, x, ux);
                if (uz > eps)  t = nearer(t, hi_z, z, uz);
                if (uz < -eps) t = nearer(t, lo_z, z, uz);
                if (t < 0) t = 0;
                p.x = clamp32(x + ((ux * t) >>> FRAC));
                p.z = clamp32(z + ((uz * t) >>> FRAC));
            end
            pending_points.push_back(p);
        endfunction

        function void check_point(t_xyz got);
            t_xyz want;
            if (pending_points.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word x=%0d y=%0d z=%0d",
                                           got.x, got.y, got.z);
                return;
            end
            want = pending_points.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("word mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                             want.x, want.y, want.z, got.x, got.y, got.z);
            end
        endfunction
    endclass

    exit_point_board board;
    int stall_pct;
    int hold_left;
    int cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle cap
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("ray_rectangle_exit_point_unit: mismatch");
            $finish;
        end
    end

    // receiver with random stalls and a long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            point_if.ready <= 1'b0;
        end else begin
            point_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // handshake monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (query_if.valid && query_if.ready)
                board.note_query(query_if.start_x, query_if.start_y, query_if.start_z,
                                 query_if.heading_x, query_if.heading_z);
            if (point_if.valid && point_if.ready)
                board.check_point('{point_if.end_x, point_if.end_y, point_if.end_z});
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic set_rect(logic [31:0] lx, hx, lz, hz, logic [15:0] e);
        reg_write(CFG_MIN_X, lx);
        reg_write(CFG_MAX_X, hx);
        reg_write(CFG_MIN_Z, lz);
        reg_write(CFG_MAX_Z, hz);
        reg_write(CFG_EPS, {16'd0, e});
    endtask

    // offer one query word, return once it is taken
    task automatic offer(logic signed [31:0] sx, sy, sz, hx, hz, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            query_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        query_if.valid     <= 1'b1;
        query_if.start_x   <= sx;
        query_if.start_y   <= sy;
        query_if.start_z   <= sz;
        query_if.heading_x <= hx;
        query_if.heading_z <= hz;
        do @(posedge i_clk); while (!(query_if.valid && query_if.ready));
    endtask

    function automatic logic signed [31:0] coord_in(longint lo, longint hi);
        longint span;
        span = hi - lo;
        if (span <= 0 || span >= 64'h1_0000_0000 || $urandom_range(7) == 0)
            return $urandom;
        return 32'(lo + longint'({$urandom, $urandom}) % (span + 1)
                   + $signed($urandom_range(64)) - 32);
    endfunction

    // mostly rays from inside the rectangle, some noise and short headings
    task automatic random_queries(int n, int idle_pct);
        logic signed [31:0] sx, sz, hx, hz;
        repeat (n) begin
            sx = coord_in(board.lo_x, board.hi_x);
            sz = coord_in(board.lo_z, board.hi_z);
            hx = $signed($urandom) >>> $urandom_range(31);
            hz = $signed($urandom) >>> $urandom_range(31);
            case ($urandom_range(9))
                0: begin sx = $urandom; sz = $urandom; hx = $urandom; hz = $urandom; end
                1: begin hx = $signed($urandom_range(16)) - 8;
                         hz = $signed($urandom_range(16)) - 8; end
                2: hx = $signed($urandom_range(6)) - 3;
                3: hz = $signed($urandom_range(6)) - 3;
                default: ;
            endcase
            offer(sx, $urandom, sz, hx, hz, idle_pct);
        end
        query_if.valid <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        board = new();
        cycles = 0;
        stall_pct = 0;
        hold_left = 0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        query_if.valid = 1'b0;
        query_if.start_x = '0; query_if.start_y = '0; query_if.start_z = '0;
        query_if.heading_x = '0; query_if.heading_z = '0;
        point_if.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at the reset rectangle
        offer(0, 5, 0, 0, 0, 0);                                  // zero heading
        offer(65536, -1, 65536, 3, 4, 0);                         // short heading
        offer(0, 32'h7FFF_FFFF, 0, 65536, 0, 0);                  // +x wall
        offer(0, 32'h8000_0000, 0, -65536, 0, 0);                 // -x wall
        offer(0, 0, 0, 0, 65536, 0);                              // +z wall
        offer(0, 0, 0, 0, -65536, 0);                             // -z wall
        offer(1000, 7, -2000, 65536, 65536, 0);                   // diagonal
        offer(5000000, 0, 0, 65536, 0, 0);                        // past wall, outward
        offer(3932160, 0, 1310720, 65536, 65536, 0);              // on the corner
        offer(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 0);          // most negative heading
        offer(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);          // largest heading
        offer(32'h7FFF_FFFF, 0, 32'h8000_0000, -65536, 65536, 0); // extreme start
        offer(0, 0, 0, 65536, 2, 0);                              // tiny z component
        query_if.valid <= 1'b0;
        drain();

        // rectangle at the range extremes, largest threshold
        set_rect(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        reg_write(3'd5, $urandom);                                // unmapped register
        offer(0, 0, 0, 65536, 0, 0);
        offer(32'h7FFF_0000, 0, 0, 0, 65536, 0);
        offer(0, 0, 0, 100, 100, 0);
        query_if.valid <= 1'b0;
        stall_pct = 0;
        random_queries(100, 0);
        drain();

        // inverted rectangle, zero threshold, idle sender
        set_rect(32'd3932160, -32'sd3932160, 32'd1310720, -32'sd6553600, 16'd0);
        offer(0, 0, 0, 1, 0, 0);
        offer(0, 0, 0, 0, 0, 0);
        stall_pct = 0;
        random_queries(100, 71);
        drain();

        // reset rectangle, stalling receiver
        set_rect(RST_MIN_X, RST_MAX_X, RST_MIN_Z, RST_MAX_Z, RST_EPS);
        stall_pct = 71;
        random_queries(100, 0);
        drain();

        // random rectangle, light idling both ways
        set_rect($signed($urandom) >>> 6, $signed($urandom) >>> 6,
                 $signed($urandom) >>> 6, $signed($urandom) >>> 6,
                 16'($urandom_range(300)));
        stall_pct = 8;
        random_queries(100, 8);
        drain();

        // long receiver hold-off while words keep coming, enough to fill the pipe
        stall_pct = 0;
        hold_left = 400;
        random_queries(200, 0);
        drain();

        if (board.errors == 0 && board.pending_points.size() == 0)
            $display("ray_rectangle_exit_point_unit: match");
        else
            $display("ray_rectangle_exit_point_unit: mismatch");
        $finish;
    end
endmodule
